// ----- design/char_stream_tokenizer_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the character stream tokenizer
// Clocked on clk, quiet while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CHAR_STREAM_TOKENIZER_UNIT_ASSERT_SVH
`define CHAR_STREAM_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication
`define CST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CST_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/cst_pkg.sv -----
// ---------------------------------------------------------------------------
// cst_pkg
// Types, character codes and scanner helper functions for the tokenizer.
// ---------------------------------------------------------------------------
package cst_pkg;

    localparam int MAX_TOKEN_LEN = 255;
    localparam int LEN_CAP       = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
    localparam logic [7:0] LEN_CAP_W = 8'(LEN_CAP);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Character codes
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_F    = 8'h46;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_BSLASH     = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_B    = 8'h62;
    localparam logic [7:0] CH_LOWER_D    = 8'h64;
    localparam logic [7:0] CH_LOWER_F    = 8'h66;
    localparam logic [7:0] CH_LOWER_N    = 8'h6E;
    localparam logic [7:0] CH_LOWER_O    = 8'h6F;
    localparam logic [7:0] CH_LOWER_R    = 8'h72;
    localparam logic [7:0] CH_LOWER_T    = 8'h74;
    localparam logic [7:0] CH_LOWER_X    = 8'h78;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_IDENT    = 3'd1,
        PH_STRING   = 3'd2,
        PH_LINE     = 3'd3,
        PH_SIGNED   = 3'd4,
        PH_ZERO     = 3'd5,
        PH_PREFIXED = 3'd6,
        PH_DIGITS   = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        K_EOF    = 3'd0,
        K_IDENT  = 3'd1,
        K_STRING = 3'd2,
        K_OTHER  = 3'd3,
        K_BIN    = 3'd4,
        K_OCT    = 3'd5,
        K_DEC    = 3'd6,
        K_HEX    = 3'd7
    } kind_t;

    typedef struct packed {
        phase_t      phase;
        kind_t       kind;
        logic        zero_pending;
        logic        negative;
        logic        quote_double;
        logic        escape;
        logic        line_token;
        logic [31:0] accum;
        logic [7:0]  len;
        logic        sat;
    } scan_st_t;

    typedef struct packed {
        logic               text_valid;
        logic [7:0]         text_byte;
        logic               token_done;
        kind_t              token_kind;
        logic signed [31:0] token_number;
        logic [7:0]         token_len;
        logic               len_saturated;
    } rec_t;

    typedef struct packed {
        rec_t rec0;
        rec_t rec1;
        logic two;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } digit_t;

    function automatic logic is_letter(logic [7:0] c);
        return c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]};
    endfunction

    function automatic logic is_dec(logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_eol(logic [7:0] c);
        return c inside {CH_CR, CH_LF};
    endfunction

    function automatic rec_t text_rec(logic [7:0] b);
        rec_t r;
        r            = '0;
        r.text_valid = 1'b1;
        r.text_byte  = b;
        return r;
    endfunction

    function automatic rec_t eof_rec();
        rec_t r;
        r            = '0;
        r.token_done = 1'b1;
        r.token_kind = K_EOF;
        return r;
    endfunction

    function automatic scan_st_t count_byte(scan_st_t s);
        scan_st_t t;
        t = s;
        if (s.len < LEN_CAP_W)
            t.len = s.len + 8'd1;
        else
            t.sat = 1'b1;
        return t;
    endfunction

    // Record that closes the token held in s, optionally with one last byte
    function automatic rec_t close_rec(scan_st_t s, logic with_byte, logic [7:0] b);
        scan_st_t t;
        rec_t     r;
        t = with_byte ? count_byte(s) : s;
        r = '0;
        r.text_valid    = with_byte;
        r.text_byte     = with_byte ? b : 8'd0;
        r.token_done    = 1'b1;
        r.token_kind    = s.kind;
        if (s.kind >= K_BIN)
            r.token_number = s.negative ? (32'd0 - s.accum) : s.accum;
        r.token_len     = t.len;
        r.len_saturated = t.sat;
        return r;
    endfunction

    function automatic scan_st_t tok_begin(scan_st_t s, phase_t ph, kind_t k);
        scan_st_t t;
        t              = '0;
        t.phase        = ph;
        t.kind         = k;
        t.quote_double = s.quote_double;
        return t;
    endfunction

    // acc * base + digit; the bases are shifts, ten is 8x + 2x
    function automatic logic [31:0] accumulate(logic [31:0] acc, kind_t k, logic [3:0] dv);
        logic [31:0] scaled;
        case (k)
            K_BIN:   scaled = acc << 1;
            K_OCT:   scaled = acc << 3;
            K_HEX:   scaled = acc << 4;
            default: scaled = (acc << 3) + (acc << 1);
        endcase
        return scaled + {28'd0, dv};
    endfunction

    function automatic digit_t digit_of(logic [7:0] c, kind_t k);
        digit_t d;
        d = '0;
        if (is_dec(c)) begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_ZERO);
        end else if (c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_UPPER_A + 8'd10);
        end else if (c inside {[CH_LOWER_A:CH_LOWER_F]}) begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_LOWER_A + 8'd10);
        end
        case (k)
            K_BIN:   if (d.val > 4'd1) d.ok = 1'b0;
            K_OCT:   if (d.val > 4'd7) d.ok = 1'b0;
            K_DEC:   if (d.val > 4'd9) d.ok = 1'b0;
            K_HEX:   d.ok = d.ok;
            default: d.ok = 1'b0;
        endcase
        return d;
    endfunction

    function automatic logic [7:0] xlat_escape(logic [7:0] c);
        case (c)
            CH_LOWER_T: return CH_TAB;
            CH_LOWER_R: return CH_CR;
            CH_LOWER_N: return CH_LF;
            default:    return c;
        endcase
    endfunction

endpackage

// ----- design/cst_ifs.sv -----
// ---------------------------------------------------------------------------
// Tokenizer channel interfaces
// Valid/ready channels for the character input and the token record output.
// ---------------------------------------------------------------------------
interface cst_char_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] char_in;
    logic       line_mode;

    modport source (output valid, action, char_in, line_mode, input ready);
    modport sink   (input valid, action, char_in, line_mode, output ready);
endinterface

interface cst_token_if;
    logic               valid;
    logic               ready;
    logic               text_valid;
    logic [7:0]         text_byte;
    logic               token_done;
    logic [2:0]         token_kind;
    logic signed [31:0] token_number;
    logic [7:0]         token_len;
    logic               len_saturated;
    logic               last_of_run;

    modport source (output valid, text_valid, text_byte, token_done, token_kind,
                    token_number, token_len, len_saturated, last_of_run,
                    input ready);
    modport sink   (input valid, text_valid, text_byte, token_done, token_kind,
                    token_number, token_len, len_saturated, last_of_run,
                    output ready);
endinterface

// ----- design/char_stream_tokenizer_unit.sv -----
// ---------------------------------------------------------------------------
// char_stream_tokenizer_unit
// Character stream tokenizer: one character in, zero to two records out.
// ---------------------------------------------------------------------------
// The unit accepts one character per cycle for as long as its four-entry
// record queue has room; the scanner settles each character within that cycle.
// Records leave at one per cycle from a registered output stage while the
// sink is ready, so a character that yields two records (a token closed and
// another begun, a held zero followed by a digit, end of input after an open
// token) sends them out one after the other, and the output port sets the
// sustained rate when such characters are frequent. With the queue ahead of
// it empty, an accepted character's records are written into a queue slot
// and then loaded into the output register, where the sink can take them.
// Reset is asynchronous and returns the scanner to the state between tokens.
// ---------------------------------------------------------------------------
module char_stream_tokenizer_unit (
    input  logic        clk,
    input  logic        rst_n,
    cst_char_if.sink    char_ch,
    cst_token_if.source token_ch
);
    import cst_pkg::*;

    logic      push;
    entry_t    push_data;
    logic      pop;
    entry_t    head;
    q_status_t q_status;

    cst_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_ch   (char_ch),
        .push      (push),
        .push_data (push_data),
        .q_status  (q_status)
    );

    cst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    cst_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .token_ch  (token_ch)
    );

endmodule

// ----- design/cst_front.sv -----
// ---------------------------------------------------------------------------
// cst_front
// Scanner: takes one character per cycle while the queue has room,
// updates the token state, queues the zero to two records it produces.
// ---------------------------------------------------------------------------
module cst_front (
    input  logic               clk,
    input  logic               rst_n,
    cst_char_if.sink           char_ch,
    output logic               push,
    output cst_pkg::entry_t    push_data,
    input  cst_pkg::q_status_t q_status
);
    import cst_pkg::*;

    scan_st_t   st_reg;
    scan_st_t   st_next;
    scan_st_t   s;
    rec_t       recs [2];
    logic [1:0] n_rec;
    logic       rescan;
    logic       fire;
    digit_t     dg;
    logic [7:0] c;

    assign char_ch.ready = !q_status.full;
    assign fire          = char_ch.valid && char_ch.ready;
    assign c             = char_ch.char_in;

    always_comb
    begin
        s       = st_reg;
        recs[0] = '0;
        recs[1] = '0;
        n_rec   = 2'd0;
        rescan  = 1'b0;
        dg      = digit_of(c, st_reg.kind);

        if (char_ch.action) begin
            // close any open token, then the end-of-input record
            if (s.phase == PH_ZERO) begin
                recs[n_rec[0]] = close_rec(s, 1'b1, CH_ZERO);
                n_rec = n_rec + 2'd1;
            end else if (s.phase != PH_IDLE) begin
                recs[n_rec[0]] = close_rec(s, 1'b0, 8'd0);
                n_rec = n_rec + 2'd1;
            end
            recs[n_rec[0]] = eof_rec();
            n_rec = n_rec + 2'd1;
            s = tok_begin(s, PH_IDLE, K_EOF);
        end else begin
            case (s.phase)
                PH_IDENT:
                begin
                    if (is_letter(c) || is_dec(c) || c == CH_UNDERSCORE) begin
                        s = count_byte(s);
                        recs[n_rec[0]] = text_rec(c);
                        n_rec = n_rec + 2'd1;
                    end else begin
                        recs[n_rec[0]] = close_rec(s, 1'b0, 8'd0);
                        n_rec = n_rec + 2'd1;
                        s = tok_begin(s, PH_IDLE, K_EOF);
                        rescan = 1'b1;
                    end
                end
                PH_STRING:
                begin
                    if (s.escape) begin
                        s.escape = 1'b0;
                        s = count_byte(s);
                        recs[n_rec[0]] = text_rec(xlat_escape(c));
                        n_rec = n_rec + 2'd1;
                    end else if (c == (s.quote_double ? CH_DQUOTE : CH_SQUOTE)) begin
                        recs[n_rec[0]] = close_rec(s, 1'b0, 8'd0);
                        n_rec = n_rec + 2'd1;
                        s = tok_begin(s, PH_IDLE, K_EOF);
                    end else if (c == CH_BSLASH) begin
                        s.escape = 1'b1;
                    end else begin
                        s = count_byte(s);
                        recs[n_rec[0]] = text_rec(c);
                        n_rec = n_rec + 2'd1;
                    end
                end
                PH_LINE:
                begin
                    if (is_eol(c)) begin
                        recs[n_rec[0]] = close_rec(s, 1'b0, 8'd0);
                        n_rec = n_rec + 2'd1;
                        s = tok_begin(s, PH_IDLE, K_EOF);
                    end else begin
                        s = count_byte(s);
                        recs[n_rec[0]] = text_rec(c);
                        n_rec = n_rec + 2'd1;
                    end
                end
                PH_SIGNED:
                begin
                    if (c == CH_ZERO) begin
                        s.phase        = PH_ZERO;
                        s.zero_pending = 1'b1;
                    end else if (is_dec(c)) begin
                        s.accum = accumulate(s.accum, s.kind, 4'(c - CH_ZERO));
                        s = count_byte(s);
                        recs[n_rec[0]] = text_rec(c);
                        n_rec = n_rec + 2'd1;
                        s.phase = PH_DIGITS;
                    end else begin
                        recs[n_rec[0]] = close_rec(s, 1'b0, 8'd0);
                        n_rec = n_rec + 2'd1;
                        s = tok_begin(s, PH_IDLE, K_EOF);
                        rescan = 1'b1;
                    end
                end
                PH_ZERO:
                begin
                    s.zero_pending = 1'b0;
                    if (c inside {CH_LOWER_B, CH_LOWER_O, CH_LOWER_D, CH_LOWER_X}) begin
                        case (c)
                            CH_LOWER_B: s.kind = K_BIN;
                            CH_LOWER_O: s.kind = K_OCT;
                            CH_LOWER_D: s.kind = K_DEC;
                            default:    s.kind = K_HEX;
                        endcase
                        s.phase = PH_PREFIXED;
                    end else if (is_dec(c)) begin
                        // the held zero goes out first, then this digit
                        s = count_byte(s);
                        recs[n_rec[0]] = text_rec(CH_ZERO);
                        n_rec = n_rec + 2'd1;
                        s.accum = accumulate(s.accum, s.kind, 4'(c - CH_ZERO));
                        s = count_byte(s);
                        recs[n_rec[0]] = text_rec(c);
                        n_rec = n_rec + 2'd1;
                        s.phase = PH_DIGITS;
                    end else begin
                        recs[n_rec[0]] = close_rec(s, 1'b1, CH_ZERO);
                        n_rec = n_rec + 2'd1;
                        s = tok_begin(s, PH_IDLE, K_EOF);
                        rescan = 1'b1;
                    end
                end
                PH_PREFIXED, PH_DIGITS:
                begin
                    if (dg.ok) begin
                        s.accum = accumulate(s.accum, s.kind, dg.val);
                        s = count_byte(s);
                        recs[n_rec[0]] = text_rec(c);
                        n_rec = n_rec + 2'd1;
                        s.phase = PH_DIGITS;
                    end else begin
                        recs[n_rec[0]] = close_rec(s, 1'b0, 8'd0);
                        n_rec = n_rec + 2'd1;
                        s = tok_begin(s, PH_IDLE, K_EOF);
                        rescan = 1'b1;
                    end
                end
                default:
                begin
                    rescan = 1'b1;
                end
            endcase

            // scan the character as between tokens
            if (rescan) begin
                if (c == CH_SPACE || c == CH_TAB) begin
                    s = s;
                end else if (is_eol(c) && !char_ch.line_mode) begin
                    s = s;
                end else if (char_ch.line_mode) begin
                    s = tok_begin(s, PH_LINE, K_OTHER);
                    s.line_token = 1'b1;
                    if (is_eol(c)) begin
                        recs[n_rec[0]] = close_rec(s, 1'b0, 8'd0);
                        n_rec = n_rec + 2'd1;
                        s = tok_begin(s, PH_IDLE, K_EOF);
                    end else begin
                        s = count_byte(s);
                        recs[n_rec[0]] = text_rec(c);
                        n_rec = n_rec + 2'd1;
                    end
                end else if (is_letter(c)) begin
                    s = tok_begin(s, PH_IDENT, K_IDENT);
                    s = count_byte(s);
                    recs[n_rec[0]] = text_rec(c);
                    n_rec = n_rec + 2'd1;
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    s = tok_begin(s, PH_SIGNED, K_DEC);
                    s.negative = (c == CH_MINUS);
                    s = count_byte(s);
                    recs[n_rec[0]] = text_rec(c);
                    n_rec = n_rec + 2'd1;
                end else if (c == CH_ZERO) begin
                    s = tok_begin(s, PH_ZERO, K_DEC);
                    s.zero_pending = 1'b1;
                end else if (is_dec(c)) begin
                    s = tok_begin(s, PH_DIGITS, K_DEC);
                    s.accum = {28'd0, 4'(c - CH_ZERO)};
                    s = count_byte(s);
                    recs[n_rec[0]] = text_rec(c);
                    n_rec = n_rec + 2'd1;
                end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
                    s = tok_begin(s, PH_STRING, K_STRING);
                    s.quote_double = (c == CH_DQUOTE);
                end else begin
                    s = tok_begin(s, PH_IDLE, K_OTHER);
                    recs[n_rec[0]] = close_rec(s, 1'b1, c);
                    n_rec = n_rec + 2'd1;
                    s = tok_begin(s, PH_IDLE, K_EOF);
                end
            end
        end

        st_next = fire ? s : st_reg;
    end

    assign push           = fire && (n_rec != 2'd0);
    assign push_data.rec0 = recs[0];
    assign push_data.rec1 = recs[1];
    assign push_data.two  = (n_rec == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else
            st_reg <= st_next;
    end

endmodule

// ----- design/cst_queue.sv -----
// ---------------------------------------------------------------------------
// cst_queue
// Short first-in first-out queue of record pairs between scanner and output.
// ---------------------------------------------------------------------------
module cst_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cst_pkg::entry_t     push_data,
    input  logic                pop,
    output cst_pkg::entry_t     head,
    output cst_pkg::q_status_t  status
);
    import cst_pkg::*;

    entry_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- design/cst_back.sv -----
// ---------------------------------------------------------------------------
// cst_back
// Output stage: splits each queued pair into single records and holds the
// current record in a register until the sink takes it.
// ---------------------------------------------------------------------------
module cst_back (
    input  logic               clk,
    input  logic               rst_n,
    input  cst_pkg::entry_t    head,
    input  cst_pkg::q_status_t q_status,
    output logic               pop,
    cst_token_if.source        token_ch
);
    import cst_pkg::*;

    logic out_valid_reg;
    logic out_valid_next;
    rec_t out_rec_reg;
    rec_t out_rec_next;
    logic out_last_reg;
    logic out_last_next;
    logic second_reg;
    logic second_next;
    logic load;

    assign load = (!out_valid_reg || token_ch.ready) && !q_status.empty;

    always_comb
    begin
        out_valid_next = out_valid_reg && !token_ch.ready;
        out_rec_next   = out_rec_reg;
        out_last_next  = out_last_reg;
        second_next    = second_reg;
        pop            = 1'b0;
        if (load) begin
            out_valid_next = 1'b1;
            if (!second_reg) begin
                out_rec_next  = head.rec0;
                out_last_next = !head.two;
                // hold the entry when its second record is still to go
                if (head.two)
                    second_next = 1'b1;
                else
                    pop = 1'b1;
            end else begin
                out_rec_next  = head.rec1;
                out_last_next = 1'b1;
                second_next   = 1'b0;
                pop           = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rec_reg  <= out_rec_next;
        out_last_reg <= out_last_next;
    end

    assign token_ch.valid         = out_valid_reg;
    assign token_ch.text_valid    = out_rec_reg.text_valid;
    assign token_ch.text_byte     = out_rec_reg.text_byte;
    assign token_ch.token_done    = out_rec_reg.token_done;
    assign token_ch.token_kind    = out_rec_reg.token_kind;
    assign token_ch.token_number  = out_rec_reg.token_number;
    assign token_ch.token_len     = out_rec_reg.token_len;
    assign token_ch.len_saturated = out_rec_reg.len_saturated;
    assign token_ch.last_of_run   = out_last_reg;

endmodule

// ----- design/cst_checker.sv -----
// ---------------------------------------------------------------------------
// cst_checker
// Port-level checks on the token record channel of the tokenizer.
// ---------------------------------------------------------------------------
`include "char_stream_tokenizer_unit_assert.svh"

module cst_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        vld,
    input  logic        rdy,
    input  logic        txv,
    input  logic [7:0]  txb,
    input  logic        dn,
    input  logic [2:0]  knd,
    input  logic [31:0] num,
    input  logic [7:0]  len,
    input  logic        sat,
    input  logic        lst
);
    import cst_pkg::*;

    logic stall;
    logic eof;

    assign stall = vld && !rdy;
    assign eof   = vld && dn && (knd == K_EOF);

    `CST_ASSERT_NXT(a_hold, stall, vld && $stable(txb) && $stable(num) && $stable(lst), "stall")
    `CST_ASSERT_IMP(a_open, vld && !dn, knd == 3'd0 && num == 32'd0 && len == 8'd0, "open rec")
    `CST_ASSERT_IMP(a_text, vld && !txv, txb == 8'd0 && !(dn == 1'b0 && sat), "text zero")
    `CST_ASSERT_IMP(a_eof, eof, lst && !txv && len == 8'd0 && num == 32'd0, "eof record")
    `CST_ASSERT_IMP(a_sat, vld && sat, dn && len == LEN_CAP_W, "saturated length")

endmodule

bind char_stream_tokenizer_unit cst_checker u_cst_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .vld   (token_ch.valid),
    .rdy   (token_ch.ready),
    .txv   (token_ch.text_valid),
    .txb   (token_ch.text_byte),
    .dn    (token_ch.token_done),
    .knd   (token_ch.token_kind),
    .num   (token_ch.token_number),
    .len   (token_ch.token_len),
    .sat   (token_ch.len_saturated),
    .lst   (token_ch.last_of_run)
);

// ----- test/tb_char_stream_tokenizer_unit.sv -----
// ---------------------------------------------------------------------------
// tb_char_stream_tokenizer_unit
// Self-checking bench for the character stream tokenizer. Characters go in
// over a valid/ready channel; every token record coming out is compared with
// an in-bench scanner model, field by field, in arrival order. Directed
// sequences hit each token rule, then long and overflowing tokens, output
// back-pressure on unpaced input and a large random run of well-formed and
// broken streams, else bursty input, all under a wandering output stall.
// ---------------------------------------------------------------------------
module tb_char_stream_tokenizer_unit;

    import cst_pkg::*;

    localparam int RANDOM_ITEMS = 260;
    localparam int LONG_HOLD    = 80;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_TAIL   = 16;

    localparam int RX_FLOW    = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;
    localparam int RX_SPARSE  = 3;

    typedef struct {
        logic        tv;
        logic [7:0]  tb;
        logic        done;
        logic [2:0]  kind;
        logic [31:0] num;
        logic [7:0]  len;
        logic        sat;
        logic        last;
    } tok_rec_t;

    logic clk = 1'b0;
    logic rst_n;

    cst_char_if  char_if ();
    cst_token_if tok_if ();

    char_stream_tokenizer_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_ch  (char_if),
        .token_ch (tok_if)
    );

    always #5 clk = ~clk;

    // Scanner model state
    phase_t      sc_phase = PH_IDLE;
    kind_t       sc_kind  = K_EOF;
    logic        sc_neg   = 1'b0;
    logic        sc_dquote = 1'b0;
    logic        sc_esc   = 1'b0;
    logic [31:0] sc_acc   = '0;
    logic [7:0]  sc_len   = '0;
    logic        sc_sat   = 1'b0;

    tok_rec_t step_recs [2];
    int       step_n;
    tok_rec_t pending_records [$];

    int  err_cnt       = 0;
    int  char_cnt      = 0;
    int  blank_cnt     = 0;
    int  recs_checked  = 0;
    int  tokens_closed = 0;
    int  sat_tokens    = 0;
    int  holdoffs_done = 0;
    int  cycle_cnt     = 0;
    bit  stall_req     = 1'b0;
    bit  pace_on       = 1'b1;
    int  burst_left    = 0;

    // -----------------------------------------------------------------------
    // Scanner model
    // -----------------------------------------------------------------------
    function automatic bit letter_ch(logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function automatic bit digit_ch(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit eol_ch(logic [7:0] c);
        return c == CH_CR || c == CH_LF;
    endfunction

    function automatic void put_rec(bit tv, logic [7:0] b, bit done, kind_t k,
                                    logic [31:0] num, logic [7:0] len, bit sat);
        if (step_n >= 2)
            return;
        step_recs[step_n].tv   = tv;
        step_recs[step_n].tb   = tv ? b : 8'h00;
        step_recs[step_n].done = done;
        step_recs[step_n].kind = done ? k : 3'd0;
        step_recs[step_n].num  = done ? num : 32'd0;
        step_recs[step_n].len  = done ? len : 8'd0;
        step_recs[step_n].sat  = done ? sat : 1'b0;
        step_recs[step_n].last = 1'b0;
        step_n++;
    endfunction

    function automatic void bump_len();
        if (sc_len < LEN_CAP_W)
            sc_len++;
        else
            sc_sat = 1'b1;
    endfunction

    function automatic void push_text(logic [7:0] b);
        bump_len();
        put_rec(1'b1, b, 1'b0, K_EOF, 32'd0, 8'd0, 1'b0);
    endfunction

    function automatic void start_tok(phase_t ph, kind_t k);
        sc_phase = ph;
        sc_kind  = k;
        sc_neg   = 1'b0;
        sc_esc   = 1'b0;
        sc_acc   = '0;
        sc_len   = '0;
        sc_sat   = 1'b0;
    endfunction

    function automatic void end_tok(bit with_b, logic [7:0] b);
        logic [31:0] num;
        num = '0;
        if (with_b)
            bump_len();
        if (sc_kind >= K_BIN)
            num = sc_neg ? 32'd0 - sc_acc : sc_acc;
        put_rec(with_b, b, 1'b1, sc_kind, num, sc_len, sc_sat);
        start_tok(PH_IDLE, K_EOF);
    endfunction

    function automatic logic [31:0] radix();
        case (sc_kind)
            K_BIN:   return 32'd2;
            K_OCT:   return 32'd8;
            K_HEX:   return 32'd16;
            default: return 32'd10;
        endcase
    endfunction

    function automatic void add_digit(int dv);
        sc_acc = sc_acc * radix() + 32'(dv);
    endfunction

    // Digit value in the base of the open number, -1 when it does not belong
    function automatic int digit_val(logic [7:0] c);
        int v;
        v = -1;
        if (digit_ch(c))
            v = int'(c - CH_ZERO);
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            v = c - CH_UPPER_A + 10;
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            v = c - CH_LOWER_A + 10;
        case (sc_kind)
            K_BIN:   if (v > 1) v = -1;
            K_OCT:   if (v > 7) v = -1;
            K_DEC:   if (v > 9) v = -1;
            K_HEX:   v = v;
            default: v = -1;
        endcase
        return v;
    endfunction

    function automatic void scan_between(logic [7:0] c, bit lm);
        if (c == CH_SPACE || c == CH_TAB)
            return;
        if (eol_ch(c) && !lm)
            return;
        if (lm)
        begin
            start_tok(PH_LINE, K_OTHER);
            if (eol_ch(c))
                end_tok(1'b0, 8'h00);
            else
                push_text(c);
        end
        else if (letter_ch(c))
        begin
            start_tok(PH_IDENT, K_IDENT);
            push_text(c);
        end
        else if (c == CH_PLUS || c == CH_MINUS)
        begin
            start_tok(PH_SIGNED, K_DEC);
            sc_neg = (c == CH_MINUS);
            push_text(c);
        end
        else if (c == CH_ZERO)
            start_tok(PH_ZERO, K_DEC);
        else if (digit_ch(c))
        begin
            start_tok(PH_DIGITS, K_DEC);
            add_digit(int'(c - CH_ZERO));
            push_text(c);
        end
        else if (c == CH_SQUOTE || c == CH_DQUOTE)
        begin
            start_tok(PH_STRING, K_STRING);
            sc_dquote = (c == CH_DQUOTE);
        end
        else
        begin
            start_tok(PH_IDLE, K_OTHER);
            end_tok(1'b1, c);
        end
    endfunction

    // Advance the model by one accepted character and queue its records
    function automatic void predict_scan(bit act, logic [7:0] c, bit lm);
        int dv;
        bit again;
        step_n = 0;
        again  = 1'b0;
        if (act)
        begin
            if (sc_phase == PH_ZERO)
                end_tok(1'b1, CH_ZERO);
            else if (sc_phase != PH_IDLE)
                end_tok(1'b0, 8'h00);
            put_rec(1'b0, 8'h00, 1'b1, K_EOF, 32'd0, 8'd0, 1'b0);
            start_tok(PH_IDLE, K_EOF);
        end
        else
        begin
            case (sc_phase)
                PH_IDENT:
                    if (letter_ch(c) || digit_ch(c) || c == CH_UNDERSCORE)
                        push_text(c);
                    else
                    begin
                        end_tok(1'b0, 8'h00);
                        again = 1'b1;
                    end
                PH_STRING:
                    if (sc_esc)
                    begin
                        sc_esc = 1'b0;
                        case (c)
                            CH_LOWER_T: push_text(CH_TAB);
                            CH_LOWER_R: push_text(CH_CR);
                            CH_LOWER_N: push_text(CH_LF);
                            default:    push_text(c);
                        endcase
                    end
                    else if (c == (sc_dquote ? CH_DQUOTE : CH_SQUOTE))
                        end_tok(1'b0, 8'h00);
                    else if (c == CH_BSLASH)
                        sc_esc = 1'b1;
                    else
                        push_text(c);
                PH_LINE:
                    if (eol_ch(c))
                        end_tok(1'b0, 8'h00);
                    else
                        push_text(c);
                PH_SIGNED:
                    if (c == CH_ZERO)
                        sc_phase = PH_ZERO;
                    else if (digit_ch(c))
                    begin
                        add_digit(int'(c - CH_ZERO));
                        push_text(c);
                        sc_phase = PH_DIGITS;
                    end
                    else
                    begin
                        end_tok(1'b0, 8'h00);
                        again = 1'b1;
                    end
                PH_ZERO:
                    if (c == CH_LOWER_B || c == CH_LOWER_O || c == CH_LOWER_D
                        || c == CH_LOWER_X)
                    begin
                        case (c)
                            CH_LOWER_B: sc_kind = K_BIN;
                            CH_LOWER_O: sc_kind = K_OCT;
                            CH_LOWER_D: sc_kind = K_DEC;
                            default:    sc_kind = K_HEX;
                        endcase
                        sc_phase = PH_PREFIXED;
                    end
                    else if (digit_ch(c))
                    begin
                        push_text(CH_ZERO);
                        add_digit(int'(c - CH_ZERO));
                        push_text(c);
                        sc_phase = PH_DIGITS;
                    end
                    else
                    begin
                        end_tok(1'b1, CH_ZERO);
                        again = 1'b1;
                    end
                PH_PREFIXED, PH_DIGITS:
                begin
                    dv = digit_val(c);
                    if (dv >= 0)
                    begin
                        add_digit(dv);
                        push_text(c);
                        sc_phase = PH_DIGITS;
                    end
                    else
                    begin
                        end_tok(1'b0, 8'h00);
                        again = 1'b1;
                    end
                end
                default:
                    again = 1'b1;
            endcase
            if (again)
                scan_between(c, lm);
        end
        if (step_n > 0)
            step_recs[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            pending_records.push_back(step_recs[i]);
    endfunction

    // -----------------------------------------------------------------------
    // Input side
    // -----------------------------------------------------------------------
    // Called at a rising edge; returns at the edge where the transaction lands or after a random idle gap behind it
    task automatic send_char(bit act, logic [7:0] c, bit lm);
        int gap;
        char_if.valid     <= 1'b1;
        char_if.action    <= act;
        char_if.char_in   <= c;
        char_if.line_mode <= lm;
        @(posedge clk);
        while (char_if.ready !== 1'b1)
            @(posedge clk);
        char_cnt++;
        predict_scan(act, c, lm);
        if (pace_on)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                gap        = $urandom_range(1, 6);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 12);
                char_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_text(string s, bit lm);
        for (int i = 0; i < s.len(); i++)
            send_char(1'b0, s[i], lm);
    endtask

    task automatic wait_drained();
        char_if.valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_eol();
        return $urandom_range(0, 1) ? CH_CR : CH_LF;
    endfunction

    function automatic bit rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_digit(kind_t k);
        int v;
        case (k)
            K_BIN:   v = $urandom_range(0, 1);
            K_OCT:   v = $urandom_range(0, 7);
            K_HEX:   v = $urandom_range(0, 15);
            default: v = $urandom_range(0, 9);
        endcase
        if (v < 10)
            return CH_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] rand_ident_tail();
        int r;
        r = $urandom_range(0, 11);
        if (r < 8)
            return $urandom_range(0, 1) ? CH_UPPER_A + 8'($urandom_range(0, 25))
                                        : CH_LOWER_A + 8'($urandom_range(0, 25));
        if (r < 11)
            return CH_ZERO + 8'($urandom_range(0, 9));
        return CH_UNDERSCORE;
    endfunction

    // Byte that stands alone as a one-character token
    function automatic logic [7:0] rand_other();
        logic [7:0] c;
        do
            c = rand_byte();
        while (letter_ch(c) || digit_ch(c) || eol_ch(c) || c == CH_SPACE || c == CH_TAB
               || c == CH_SQUOTE || c == CH_DQUOTE || c == CH_PLUS || c == CH_MINUS);
        return c;
    endfunction

    task automatic gen_number();
        kind_t k;
        int    n;
        int    sgn;
        k   = K_DEC;
        sgn = $urandom_range(0, 2);
        if (sgn == 1)
            send_char(1'b0, CH_PLUS, 1'b0);
        else if (sgn == 2)
            send_char(1'b0, CH_MINUS, 1'b0);
        if ($urandom_range(0, 2) != 0)
        begin
            send_char(1'b0, CH_ZERO, rand_bit());
            case ($urandom_range(0, 3))
                0:       k = K_BIN;
                1:       k = K_OCT;
                2:       k = K_DEC;
                default: k = K_HEX;
            endcase
            case (k)
                K_BIN:   send_char(1'b0, CH_LOWER_B, rand_bit());
                K_OCT:   send_char(1'b0, CH_LOWER_O, rand_bit());
                K_DEC:   send_char(1'b0, CH_LOWER_D, rand_bit());
                default: send_char(1'b0, CH_LOWER_X, rand_bit());
            endcase
            n = $urandom_range(0, 12);
        end
        else
            n = $urandom_range(1, 11);
        repeat (n) send_char(1'b0, rand_digit(k), rand_bit());
        // Occasionally break the number with a character outside its base
        if ($urandom_range(0, 5) == 0)
        begin
            case (k)
                K_BIN:   send_char(1'b0, CH_ZERO + 8'd2, 1'b0);
                K_OCT:   send_char(1'b0, CH_NINE, 1'b0);
                K_DEC:   send_char(1'b0, CH_LOWER_A, 1'b0);
                default: send_char(1'b0, CH_LOWER_F + 8'd1, 1'b0);
            endcase
        end
    endtask

    task automatic gen_string(int n, int esc_every);
        logic [7:0] q;
        logic [7:0] c;
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        send_char(1'b0, q, 1'b0);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(1, esc_every) == 1)
            begin
                send_char(1'b0, CH_BSLASH, rand_bit());
                case ($urandom_range(0, 5))
                    0:       c = CH_LOWER_T;
                    1:       c = CH_LOWER_R;
                    2:       c = CH_LOWER_N;
                    3:       c = CH_BSLASH;
                    4:       c = q;
                    default: c = rand_byte();
                endcase
            end
            else
            begin
                do
                    c = rand_byte();
                while (c == q || c == CH_BSLASH);
            end
            send_char(1'b0, c, rand_bit());
        end
        if ($urandom_range(0, 7) == 0)
            send_char(1'b1, rand_byte(), rand_bit());
        else
            send_char(1'b0, q, rand_bit());
    endtask

    task automatic gen_line(int n);
        logic [7:0] c;
        if ($urandom_range(0, 5) == 0)
        begin
            send_char(1'b0, rand_eol(), 1'b1);
            return;
        end
        send_char(1'b0, 8'($urandom_range(8'h21, 8'hFF)), 1'b1);
        repeat (n)
        begin
            do
                c = rand_byte();
            while (eol_ch(c));
            send_char(1'b0, c, rand_bit());
        end
        send_char(1'b0, rand_eol(), rand_bit());
    endtask

    task automatic gen_token();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 22)
        begin
            send_char(1'b0, $urandom_range(0, 1) ? CH_UPPER_A + 8'($urandom_range(0, 25))
                                                 : CH_LOWER_A + 8'($urandom_range(0, 25)),
                      1'b0);
            repeat ($urandom_range(0, 8)) send_char(1'b0, rand_ident_tail(), rand_bit());
        end
        else if (pick < 47)
            gen_number();
        else if (pick < 62)
            gen_string($urandom_range(0, 10), 5);
        else if (pick < 72)
            gen_line($urandom_range(0, 15));
        else if (pick < 84)
            send_char(1'b0, rand_other(), 1'b0);
        else if (pick < 94)
            repeat ($urandom_range(1, 4)) send_char(1'b0, rand_byte(), rand_bit());
        else
            send_char(1'b1, rand_byte(), rand_bit());
    endtask

    task automatic gen_blanks();
        int n;
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2);
        repeat (n)
        begin
            case ($urandom_range(0, 3))
                0:       send_char(1'b0, CH_SPACE, 1'b0);
                1:       send_char(1'b0, CH_TAB, 1'b0);
                2:       send_char(1'b0, CH_CR, 1'b0);
                default: send_char(1'b0, CH_LF, 1'b0);
            endcase
            blank_cnt++;
        end
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    task automatic test_directed();
        send_text("a_Z9,", 1'b0);               // identifier closed by a lone other
        send_text("\"\\t'\\q\"", 1'b0);         // escapes, foreign quote inside
        send_text("-0xg", 1'b0);                // sign and prefix, bad first digit
        send_text("0o8", 1'b0);                 // octal prefix, bad first digit
        send_char(1'b0, CH_LF, 1'b1);           // empty line token
        send_char(1'b0, 8'hFF, 1'b1);
        send_char(1'b0, 8'h00, 1'b0);
        send_char(1'b0, CH_CR, 1'b1);
        send_char(1'b0, CH_ZERO, 1'b0);         // held zero closed by end of input
        send_char(1'b1, 8'hFF, 1'b1);
        send_text("'\\", 1'b0);                 // pending escape dropped at end
        send_char(1'b1, 8'h00, 1'b0);
        wait_drained();
    endtask

    task automatic test_value_wrap();
        send_text("0xFFFFFFFFF7 -4294967297 0o77777777777 +0 0d0 -0b", 1'b0);
        send_text("101010101010101010101010101010101 99999999999 ", 1'b0);
        send_char(1'b1, 8'h00, 1'b0);
    endtask

    task automatic test_long_tokens();
        send_char(1'b0, CH_LOWER_A + 8'($urandom_range(0, 25)), 1'b0);
        repeat (299) send_char(1'b0, rand_ident_tail(), rand_bit());
        send_char(1'b0, CH_SPACE, 1'b0);
        gen_string(270, 20);
        send_char(1'b0, CH_SPACE, 1'b0);
        send_char(1'b0, CH_LOWER_Z, 1'b1);
        repeat (260) send_char(1'b0, CH_UPPER_A + 8'($urandom_range(0, 25)), rand_bit());
        send_char(1'b0, CH_LF, 1'b0);
        send_char(1'b1, 8'h00, 1'b0);
    endtask

    // Hold the output off while characters are offered at full rate
    task automatic test_backpressure();
        int base;
        base    = char_cnt;
        pace_on = 1'b0;
        stall_req = 1'b1;
        while (char_cnt - base < 60)
            gen_token();
        pace_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_random();
        int  base;
        bit  stalled;
        base    = char_cnt - blank_cnt;
        stalled = 1'b0;
        while ((char_cnt - blank_cnt) - base < RANDOM_ITEMS)
        begin
            if (!stalled && (char_cnt - blank_cnt) - base > RANDOM_ITEMS / 2)
            begin
                stall_req = 1'b1;
                stalled   = 1'b1;
            end
            gen_token();
            gen_blanks();
        end
        send_char(1'b1, rand_byte(), rand_bit());
    endtask

    // -----------------------------------------------------------------------
    // Output side
    // -----------------------------------------------------------------------
    initial
    begin : sink_driver
        int hold_left;
        int mode_left;
        int rx_mode;
        int tick;
        hold_left = 0;
        mode_left = 0;
        rx_mode   = RX_FLOW;
        tick      = 0;
        tok_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (stall_req)
            begin
                stall_req = 1'b0;
                hold_left = LONG_HOLD;
                holdoffs_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                tok_if.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = $urandom_range(RX_FLOW, RX_SPARSE);
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (rx_mode)
                    RX_RANDOM:  tok_if.ready <= rand_bit();
                    RX_PATTERN: tok_if.ready <= (tick % 5) < 3;
                    RX_SPARSE:  tok_if.ready <= ($urandom_range(0, 3) != 0);
                    default:    tok_if.ready <= 1'b1;
                endcase
            end
        end
    end

    function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            err_cnt++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : record_check
        tok_rec_t want;
        if (rst_n === 1'b1 && tok_if.valid === 1'b1 && tok_if.ready === 1'b1)
        begin
            if (pending_records.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected record: expected none, actual byte %0h kind %0d",
                         $time, tok_if.text_byte, tok_if.token_kind);
            end
            else
            begin
                want = pending_records.pop_front();
                recs_checked++;
                if (want.done)
                    tokens_closed++;
                if (want.sat)
                    sat_tokens++;
                cmp_field("text_valid", 32'(want.tv), 32'(tok_if.text_valid));
                cmp_field("text_byte", 32'(want.tb), 32'(tok_if.text_byte));
                cmp_field("token_done", 32'(want.done), 32'(tok_if.token_done));
                cmp_field("token_kind", 32'(want.kind), 32'(tok_if.token_kind));
                cmp_field("token_number", want.num, tok_if.token_number);
                cmp_field("token_len", 32'(want.len), 32'(tok_if.token_len));
                cmp_field("len_saturated", 32'(want.sat), 32'(tok_if.len_saturated));
                cmp_field("last_of_run", 32'(want.last), 32'(tok_if.last_of_run));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("%0t: run limit reached with %0d records outstanding",
                     $time, pending_records.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        char_if.valid     = 1'b0;
        char_if.action    = 1'b0;
        char_if.char_in   = 8'h00;
        char_if.line_mode = 1'b0;
        start_tok(PH_IDLE, K_EOF);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_value_wrap();
        test_long_tokens();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Run covered %0d characters (%0d blanks), %0d records, %0d tokens closed",
                 char_cnt, blank_cnt, recs_checked, tokens_closed);
        $display("Saturated tokens: %0d, long output hold-offs: %0d, mismatches: %0d",
                 sat_tokens, holdoffs_done, err_cnt);
        if (err_cnt == 0 && pending_records.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
